/* sv/word_wrap_text_measure_macros.svh */
// Assertion macros for the checker file of the text measurement block.
// Depends on nothing; take in by `include.
`ifndef WORD_WRAP_TEXT_MEASURE_MACROS_SVH
`define WORD_WRAP_TEXT_MEASURE_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define WWM_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("wwm check failed");

// Next-cycle implication, disabled while reset is low.
`define WWM_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("wwm check failed");

`endif

/* sv/wwm_pkg.sv */
// Constants and types for the greedy word-wrap text measurement block.
// No dependencies; used by the top level and its checker.
package wwm_pkg;

    localparam int COUNT_W   = 20;
    localparam int OUT_W_W   = 24;
    localparam int HEIGHT_W  = 28;
    localparam int CHAR_W    = 8;
    localparam int ADV_W     = 8;
    localparam int WRAP_W    = 16;
    localparam int LINE_H_W  = 8;
    localparam int CFG_IDX_W = 1;
    localparam int IN_DATA_W = 16;
    localparam int OUT_DATA_W = 96;

    localparam logic [CHAR_W-1:0]   CH_SPACE       = 8'h20;
    localparam logic [CHAR_W-1:0]   CH_NEWLINE     = 8'h0A;
    localparam logic [ADV_W-1:0]    MISSING_ADV    = 8'd4;
    localparam logic [LINE_H_W-1:0] DEFAULT_LINE_H = 8'd10;
    localparam logic [COUNT_W-1:0]  COUNT_MAX      = 20'hFFFFF;
    localparam logic [OUT_W_W-1:0]  OUT_W_MAX      = 24'hFFFFFF;

    localparam logic [CFG_IDX_W-1:0] REG_WRAP_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_HEIGHT = 1'b1;

    typedef struct packed {
        logic                  end_marker;
        logic                  glyph_present;
        logic [ADV_W-1:0]      advance;
        logic [CHAR_W-1:0]     char_code;
    } t_in_item;

    typedef struct packed {
        logic [COUNT_W-1:0]  char_total;
        logic [COUNT_W-1:0]  line_total;
        logic [HEIGHT_W-1:0] total_height;
        logic [OUT_W_W-1:0]  total_width;
    } t_result;

    function automatic logic [COUNT_W-1:0] sat_c(input logic [COUNT_W:0] s);
        return s[COUNT_W] ? COUNT_MAX : s[COUNT_W-1:0];
    endfunction

endpackage

/* sv/word_wrap_text_measure.sv */
// An accepted end marker passes through the input register, then the result register,
// and its result is then held on m_axis. Throughput: one request per cycle, set by the
// single pass of adders and compares between the input register and the result register;
// an end marker waits only while an earlier result is still held on m_axis.
// Reset (synchronous, active low) clears all accumulators, line count to one,
// wrap_width to 0 and line_height to 10.
module word_wrap_text_measure #(
    parameter int WIDTH_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // tdata: char_code[7:0], advance[15:8]
    input  logic [wwm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: glyph_present
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // tdata: total_width[23:0], total_height[51:24], line_total[71:52],
    //        char_total[91:72], zero[95:92]
    output logic [wwm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_we,
    input  logic [wwm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wwm_pkg::WRAP_W-1:0]        i_cfg_wdata
);

    localparam int W  = WIDTH_BITS;
    localparam int CW = wwm_pkg::COUNT_W;

    function automatic logic [W-1:0] sat_w(input logic [W:0] s);
        return s[W] ? {W{1'b1}} : s[W-1:0];
    endfunction

    logic [wwm_pkg::WRAP_W-1:0]   r_wrap_w;
    logic [wwm_pkg::LINE_H_W-1:0] r_line_h;

    logic              r_in_valid;
    wwm_pkg::t_in_item r_in;
    logic              r_out_valid;
    wwm_pkg::t_result  r_out;

    logic [W-1:0]  r_word_w, r_line_w, r_widest;
    logic [CW-1:0] r_word_n, r_lines, r_chars;
    logic [W-1:0]  n_word_w, n_line_w, n_widest;
    logic [CW-1:0] n_word_n, n_lines, n_chars;
    wwm_pkg::t_result n_out;

    logic          proceed;
    logic          nowrap;
    logic [W:0]    ww_ext;
    logic [W:0]    sum_lw, sum_sp;
    logic          pw, brk1;
    logic [W-1:0]  l1, wid1, end_w, nw_w;
    logic [CW-1:0] lines1, chars1, end_lines;
    logic [wwm_pkg::ADV_W-1:0] adv_wrap, adv_nowrap;
    logic [32:0]   end_w_ext;

    assign proceed       = r_in_valid && (!r_in.end_marker || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proceed;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_w <= '0;
            r_line_h <= wwm_pkg::DEFAULT_LINE_H;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == wwm_pkg::REG_WRAP_WIDTH) begin
                r_wrap_w <= i_cfg_wdata;
            end else if (i_cfg_idx == wwm_pkg::REG_LINE_HEIGHT) begin
                r_line_h <= i_cfg_wdata[wwm_pkg::LINE_H_W-1:0];
            end
        end
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.char_code     <= s_axis_tdata[7:0];
            r_in.advance       <= s_axis_tdata[15:8];
            r_in.glyph_present <= s_axis_tuser;
            r_in.end_marker    <= s_axis_tlast;
        end
    end

    always_comb begin
        nowrap     = (r_wrap_w == '0);
        ww_ext     = {{(W-15){1'b0}}, r_wrap_w};
        adv_wrap   = r_in.glyph_present ? r_in.advance : '0;
        adv_nowrap = r_in.glyph_present ? r_in.advance : wwm_pkg::MISSING_ADV;

        // Place the pending word on the current line
        sum_lw = {1'b0, r_line_w} + {1'b0, r_word_w};
        pw     = (r_word_n != '0);
        brk1   = pw && (sum_lw > ww_ext) && (r_line_w != '0);
        l1     = !pw ? r_line_w : (brk1 ? r_word_w : sat_w(sum_lw));
        wid1   = (brk1 && (r_line_w > r_widest)) ? r_line_w : r_widest;
        lines1 = brk1 ? wwm_pkg::sat_c({1'b0, r_lines} + (CW+1)'(1)) : r_lines;
        chars1 = pw ? wwm_pkg::sat_c({1'b0, r_chars} + {1'b0, r_word_n}) : r_chars;

        sum_sp = {1'b0, l1} + {{(W-7){1'b0}}, adv_wrap};
        nw_w   = sat_w(sum_lw);

        n_word_w = r_word_w;
        n_word_n = r_word_n;
        n_line_w = r_line_w;
        n_widest = r_widest;
        n_lines  = r_lines;
        n_chars  = r_chars;

        if (nowrap) begin
            end_w     = (r_widest > nw_w) ? r_widest : nw_w;
            end_lines = CW'(1);
            n_out.char_total = wwm_pkg::sat_c({1'b0, r_chars} + {1'b0, r_word_n});
        end else begin
            end_w     = (l1 > wid1) ? l1 : wid1;
            end_lines = lines1;
            n_out.char_total = chars1;
        end
        end_w_ext          = 33'(end_w);
        n_out.total_width  = (end_w_ext > 33'(wwm_pkg::OUT_W_MAX)) ? wwm_pkg::OUT_W_MAX
                                                                   : end_w_ext[23:0];
        n_out.line_total   = end_lines;
        n_out.total_height = wwm_pkg::HEIGHT_W'(end_lines) *
                             wwm_pkg::HEIGHT_W'(r_line_h);

        if (r_in.end_marker) begin
            // Result taken; return to the empty string
            n_word_w = '0;
            n_word_n = '0;
            n_line_w = '0;
            n_widest = '0;
            n_lines  = CW'(1);
            n_chars  = '0;
        end else if (nowrap) begin
            n_line_w = sat_w({1'b0, r_line_w} + {{(W-7){1'b0}}, adv_nowrap});
            n_chars  = wwm_pkg::sat_c({1'b0, r_chars} + (CW+1)'(1));
        end else if (r_in.char_code == wwm_pkg::CH_SPACE) begin
            n_word_w = '0;
            n_word_n = '0;
            n_chars  = wwm_pkg::sat_c({1'b0, chars1} + (CW+1)'(1));
            if (sum_sp > ww_ext) begin
                // Space does not fit: open a new line, drop its width
                n_lines  = wwm_pkg::sat_c({1'b0, lines1} + (CW+1)'(1));
                n_widest = (l1 > wid1) ? l1 : wid1;
                n_line_w = '0;
            end else begin
                n_lines  = lines1;
                n_widest = wid1;
                n_line_w = sat_w(sum_sp);
            end
        end else if (r_in.char_code == wwm_pkg::CH_NEWLINE) begin
            n_word_w = '0;
            n_word_n = '0;
            n_chars  = wwm_pkg::sat_c({1'b0, chars1} + (CW+1)'(1));
            n_lines  = wwm_pkg::sat_c({1'b0, lines1} + (CW+1)'(1));
            n_widest = (l1 > wid1) ? l1 : wid1;
            n_line_w = '0;
        end else begin
            n_word_w = sat_w({1'b0, r_word_w} + {{(W-7){1'b0}}, adv_wrap});
            n_word_n = wwm_pkg::sat_c({1'b0, r_word_n} + (CW+1)'(1));
        end
    end

    // Measurement state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_word_w <= '0;
            r_word_n <= '0;
            r_line_w <= '0;
            r_widest <= '0;
            r_lines  <= CW'(1);
            r_chars  <= '0;
        end else if (proceed) begin
            r_word_w <= n_word_w;
            r_word_n <= n_word_n;
            r_line_w <= n_line_w;
            r_widest <= n_widest;
            r_lines  <= n_lines;
            r_chars  <= n_chars;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proceed && r_in.end_marker) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proceed && r_in.end_marker) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0, r_out};

endmodule

/* sv/wwm_checker.sv */
// Port-level checks for the text measurement block, bound to the top level.
// Depends on wwm_pkg and word_wrap_text_measure_macros.svh.
`include "word_wrap_text_measure_macros.svh"

module wwm_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic [wwm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input logic                              m_axis_tvalid,
    input logic                              m_axis_tready,
    input logic                              i_cfg_we,
    input logic [wwm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input logic [wwm_pkg::WRAP_W-1:0]        i_cfg_wdata
);

    logic [wwm_pkg::WRAP_W-1:0]   r_wrap_w;
    logic [wwm_pkg::LINE_H_W-1:0] r_line_h;
    logic [wwm_pkg::HEIGHT_W-1:0] expect_h;

    // Track the configuration as written
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wrap_w <= '0;
            r_line_h <= wwm_pkg::DEFAULT_LINE_H;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == wwm_pkg::REG_WRAP_WIDTH) begin
                r_wrap_w <= i_cfg_wdata;
            end else if (i_cfg_idx == wwm_pkg::REG_LINE_HEIGHT) begin
                r_line_h <= i_cfg_wdata[wwm_pkg::LINE_H_W-1:0];
            end
        end
    end

    assign expect_h = wwm_pkg::HEIGHT_W'(m_axis_tdata[71:52]) *
                      wwm_pkg::HEIGHT_W'(r_line_h);

    `WWM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
    `WWM_ASSERT_NOW(a_lines_nonzero, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[71:52] != '0)
    `WWM_ASSERT_NOW(a_nowrap_one_line, i_clk, i_rst_n, m_axis_tvalid && (r_wrap_w == '0), m_axis_tdata[71:52] == 20'd1)
    `WWM_ASSERT_NOW(a_height_product, i_clk, i_rst_n, m_axis_tvalid, m_axis_tdata[51:24] == expect_h)

endmodule

bind word_wrap_text_measure wwm_checker u_wwm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .i_cfg_we      (i_cfg_we),
    .i_cfg_idx     (i_cfg_idx),
    .i_cfg_wdata   (i_cfg_wdata)
);

/* test/word_wrap_text_measure_checker.sv */
// Checker for the word-wrap text measurement block: follows the request and result
// streams and the register port, predicts each measurement and compares it field by field.
// Depends on wwm_pkg.
module word_wrap_text_measure_checker #(
    parameter int WIDTH_BITS = 24
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [wwm_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    input  logic                              s_axis_tuser,
    input  logic                              s_axis_tlast,
    input  logic                              s_axis_tvalid,
    input  logic                              s_axis_tready,
    input  logic [wwm_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    input  logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    input  logic                              i_cfg_we,
    input  logic [wwm_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [wwm_pkg::WRAP_W-1:0]        i_cfg_wdata,
    output int                                o_errors,
    output int                                o_open,
    output int                                o_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW = wwm_pkg::COUNT_W;
    localparam int RW = $bits(wwm_pkg::t_result);

    typedef logic [WIDTH_BITS-1:0] t_px;

    // register copies
    logic [wwm_pkg::WRAP_W-1:0]   wrap_px;
    logic [wwm_pkg::LINE_H_W-1:0] line_h;

    // running measurement of the current string
    t_px           word_px;
    t_px           line_px;
    t_px           widest_px;
    logic [CW-1:0] word_chars;
    logic [CW-1:0] line_count;
    logic [CW-1:0] char_count;

    wwm_pkg::t_result measure_due[$];

    function automatic t_px add_px(input t_px a, input t_px b);
        logic [WIDTH_BITS:0] s;
        s = a + b;
        return s[WIDTH_BITS] ? '1 : s[WIDTH_BITS-1:0];
    endfunction

    function automatic logic [CW-1:0] add_count(input logic [CW-1:0] a,
                                                input logic [CW-1:0] b);
        logic [CW:0] s;
        s = a + b;
        return s[CW] ? wwm_pkg::COUNT_MAX : s[CW-1:0];
    endfunction

    task automatic clear_measure();
        word_px    = '0;
        line_px    = '0;
        widest_px  = '0;
        word_chars = '0;
        line_count = CW'(1);
        char_count = '0;
    endtask

    task automatic open_line();
        line_count = add_count(line_count, CW'(1));
        if (line_px > widest_px) widest_px = line_px;
        line_px = '0;
    endtask

    // place the pending word greedily on the current line
    task automatic settle_word();
        if (word_chars == '0) return;
        if (({1'b0, line_px} + word_px) > wrap_px && line_px != '0) open_line();
        line_px    = add_px(line_px, word_px);
        char_count = add_count(char_count, word_chars);
        word_px    = '0;
        word_chars = '0;
    endtask

    task automatic fold_char(input wwm_pkg::t_in_item req);
        t_px glyph_px;
        glyph_px = req.glyph_present ? t_px'(req.advance) : '0;
        if (wrap_px == '0) begin
            // no-wrap: every character widens the line, missing glyphs get a fixed width
            line_px    = add_px(line_px, req.glyph_present ? t_px'(req.advance)
                                                           : t_px'(wwm_pkg::MISSING_ADV));
            char_count = add_count(char_count, CW'(1));
        end else if (req.char_code == wwm_pkg::CH_SPACE) begin
            settle_word();
            // a space that does not fit starts a new line and is dropped
            if (({1'b0, line_px} + glyph_px) > wrap_px) begin
                open_line();
            end else begin
                line_px = add_px(line_px, glyph_px);
            end
            char_count = add_count(char_count, CW'(1));
        end else if (req.char_code == wwm_pkg::CH_NEWLINE) begin
            settle_word();
            open_line();
            char_count = add_count(char_count, CW'(1));
        end else begin
            word_px    = add_px(word_px, glyph_px);
            word_chars = add_count(word_chars, CW'(1));
        end
    endtask

    task automatic close_string(output wwm_pkg::t_result res);
        t_px           width;
        logic [CW-1:0] lines;
        logic [CW-1:0] chars;
        if (wrap_px == '0) begin
            width = add_px(line_px, word_px);
            if (widest_px > width) width = widest_px;
            lines = CW'(1);
            chars = add_count(char_count, word_chars);
        end else begin
            settle_word();
            if (line_px > widest_px) widest_px = line_px;
            width = widest_px;
            lines = line_count;
            chars = char_count;
        end
        res.total_width  = (width > wwm_pkg::OUT_W_MAX) ? wwm_pkg::OUT_W_MAX
                                                        : wwm_pkg::OUT_W_W'(width);
        res.total_height = wwm_pkg::HEIGHT_W'(lines) * wwm_pkg::HEIGHT_W'(line_h);
        res.line_total   = lines;
        res.char_total   = chars;
        clear_measure();
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want != got) begin
            o_errors++;
            $display("%0t ns mismatch %s: expected %0d, actual %0d",
                     $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        wwm_pkg::t_in_item req;
        wwm_pkg::t_result  got;
        wwm_pkg::t_result  want;
        if (!i_rst_n) begin
            wrap_px = '0;
            line_h  = wwm_pkg::DEFAULT_LINE_H;
            clear_measure();
            measure_due.delete();
            o_open = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    wwm_pkg::REG_WRAP_WIDTH: wrap_px = i_cfg_wdata;
                    wwm_pkg::REG_LINE_HEIGHT: line_h = i_cfg_wdata[wwm_pkg::LINE_H_W-1:0];
                    default: ;
                endcase
            end
            // compare before taking a new request, so a stray result cannot match it
            if (m_axis_tvalid && m_axis_tready) begin
                got = wwm_pkg::t_result'(m_axis_tdata[RW-1:0]);
                if (measure_due.size() == 0) begin
                    o_errors++;
                    $display("%0t ns mismatch: expected no result, actual %h",
                             $time, m_axis_tdata);
                end else begin
                    want = measure_due.pop_front();
                    check_field("total_width", 64'(want.total_width), 64'(got.total_width));
                    check_field("total_height", 64'(want.total_height),
                                64'(got.total_height));
                    check_field("line_total", 64'(want.line_total), 64'(got.line_total));
                    check_field("char_total", 64'(want.char_total), 64'(got.char_total));
                    check_field("padding", 64'(0),
                                64'(m_axis_tdata[wwm_pkg::OUT_DATA_W-1:RW]));
                    o_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                req = wwm_pkg::t_in_item'({s_axis_tlast, s_axis_tuser, s_axis_tdata});
                if (req.end_marker) begin
                    close_string(want);
                    measure_due.push_back(want);
                end else begin
                    fold_char(req);
                end
            end
            o_open = measure_due.size();
        end
    end

endmodule

/* test/word_wrap_text_measure_tb.sv */
// Testbench top for word_wrap_text_measure: clock, reset, request and register stimulus.
// Depends on wwm_pkg, the block and word_wrap_text_measure_checker.
module word_wrap_text_measure_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT   = 200_000;
    localparam int SETTLE_CYCLES = 6;
    localparam int PHASES        = 10;
    localparam int PHASE_ITEMS   = 100;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic [wwm_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic                           s_axis_tuser = 1'b0;
    logic                           s_axis_tlast = 1'b0;
    logic                           s_axis_tvalid = 1'b0;
    logic                           s_axis_tready;
    logic [wwm_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                           m_axis_tvalid;
    logic                           m_axis_tready = 1'b0;
    logic                           i_cfg_we = 1'b0;
    logic [wwm_pkg::CFG_IDX_W-1:0]  i_cfg_idx = '0;
    logic [wwm_pkg::WRAP_W-1:0]     i_cfg_wdata = '0;

    bit steady = 1'b0;
    int errors;
    int open_n;
    int checked_n;
    int cycle_n = 0;
    int strings_sent = 0;
    int chars_sent = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    word_wrap_text_measure dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    word_wrap_text_measure_checker chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_wdata   (i_cfg_wdata),
        .o_errors      (errors),
        .o_open        (open_n),
        .o_checked     (checked_n)
    );

    // stall the result side at random, never during the steady stretch
    always @(posedge i_clk) begin
        m_axis_tready <= steady || ($urandom_range(99) >= 21);
    end

    task automatic send_item(input logic [wwm_pkg::CHAR_W-1:0] code,
                             input logic [wwm_pkg::ADV_W-1:0] adv,
                             input logic present, input logic last);
        while (!steady && $urandom_range(99) < 21) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tdata  <= {adv, code};
        s_axis_tuser  <= present;
        s_axis_tlast  <= last;
        s_axis_tvalid <= 1'b1;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (last) strings_sent++;
        else chars_sent++;
    endtask

    // end marker; the character fields carry noise
    task automatic send_end();
        send_item(wwm_pkg::CHAR_W'($urandom), wwm_pkg::ADV_W'($urandom), 1'($urandom), 1'b1);
    endtask

    // hold off until every measurement has come back and the pipeline is empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (open_n != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [wwm_pkg::CFG_IDX_W-1:0] idx,
                             input logic [wwm_pkg::WRAP_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_layout(input logic [wwm_pkg::WRAP_W-1:0] wrap,
                              input logic [wwm_pkg::LINE_H_W-1:0] lh);
        drain();
        write_reg(wwm_pkg::REG_WRAP_WIDTH, wrap);
        // upper write-data bits are junk for the line height register
        write_reg(wwm_pkg::REG_LINE_HEIGHT, {8'($urandom), lh});
    endtask

    // text-like string: mostly letters, some spaces, newlines and stray bytes
    task automatic send_text(input int max_len, input bit closed, output int n);
        int len;
        int adv_hi;
        int r;
        logic [wwm_pkg::CHAR_W-1:0] code;
        len    = $urandom_range(max_len);
        adv_hi = ($urandom_range(3) == 0) ? 255 : 12;
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(99);
            if (r < 68) code = 8'h61 + 8'($urandom_range(25));
            else if (r < 84) code = wwm_pkg::CH_SPACE;
            else if (r < 92) code = wwm_pkg::CH_NEWLINE;
            else code = wwm_pkg::CHAR_W'($urandom);
            send_item(code, wwm_pkg::ADV_W'($urandom_range(adv_hi)),
                      $urandom_range(99) < 90, 1'b0);
        end
        if (closed) send_end();
        n = len + int'(closed);
    endtask

    initial begin
        while (cycle_n < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_n++;
        end
        $display("tb: failure");
        $finish;
    end

    initial begin
        int n;
        int done;
        logic [wwm_pkg::WRAP_W-1:0]   wrap_v;
        logic [wwm_pkg::LINE_H_W-1:0] lh_v;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no-wrap defaults: empty string, missing glyph, byte extremes
        send_end();
        send_item(8'h61, 8'd255, 1'b1, 1'b0);
        send_item(8'hFF, 8'd7, 1'b0, 1'b0);
        send_item(wwm_pkg::CH_SPACE, 8'd3, 1'b1, 1'b0);
        send_item(wwm_pkg::CH_NEWLINE, 8'd0, 1'b1, 1'b0);
        send_item(8'h00, 8'd128, 1'b1, 1'b0);
        send_end();

        // wrap at 20 px: fitting and failing spaces, newline, overlong word
        set_layout(16'd20, 8'd255);
        send_end();
        send_item(8'h61, 8'd8, 1'b1, 1'b0);
        send_item(8'h62, 8'd8, 1'b1, 1'b0);
        send_item(wwm_pkg::CH_SPACE, 8'd3, 1'b1, 1'b0);
        send_item(8'h63, 8'd5, 1'b1, 1'b0);
        send_item(wwm_pkg::CH_SPACE, 8'd255, 1'b1, 1'b0);
        send_item(wwm_pkg::CH_NEWLINE, 8'd9, 1'b1, 1'b0);
        send_item(8'h78, 8'd255, 1'b0, 1'b0);
        send_item(8'h79, 8'd255, 1'b1, 1'b0);
        send_item(8'h7A, 8'd255, 1'b1, 1'b0);
        send_item(wwm_pkg::CH_SPACE, 8'd0, 1'b0, 1'b0);
        send_end();

        // switch the mode part way through a string, both directions
        send_item(8'h70, 8'd9, 1'b1, 1'b0);
        send_item(wwm_pkg::CH_SPACE, 8'd2, 1'b1, 1'b0);
        send_item(8'h71, 8'd9, 1'b1, 1'b0);
        drain();
        write_reg(wwm_pkg::REG_WRAP_WIDTH, 16'd0);
        send_item(8'h72, 8'd1, 1'b0, 1'b0);
        send_end();
        send_item(8'h73, 8'd6, 1'b1, 1'b0);
        drain();
        write_reg(wwm_pkg::REG_WRAP_WIDTH, 16'hFFFF);
        send_item(8'h74, 8'd6, 1'b1, 1'b0);
        send_item(wwm_pkg::CH_SPACE, 8'd1, 1'b1, 1'b0);
        send_end();

        for (int p = 0; p < PHASES; p++) begin
            case (p % 5)
                0: wrap_v = 16'd0;
                1: wrap_v = 16'd1;
                2: wrap_v = 16'hFFFF;
                3: wrap_v = wwm_pkg::WRAP_W'($urandom_range(1, 80));
                default: wrap_v = wwm_pkg::WRAP_W'($urandom_range(20, 300));
            endcase
            case (p % 3)
                0: lh_v = 8'hFF;
                1: lh_v = 8'h00;
                default: lh_v = wwm_pkg::LINE_H_W'($urandom);
            endcase
            set_layout(wrap_v, lh_v);
            steady = (p == 6);
            done = 0;
            while (done < PHASE_ITEMS) begin
                send_text(24, 1'b1, n);
                done += n;
            end
            // sometimes leave a string open across the next register change
            if ($urandom_range(1) == 1) send_text(6, 1'b0, n);
        end
        steady = 1'b0;
        send_end();

        drain();
        $display("run covered %0d strings and %0d characters, %0d measurements compared",
                 strings_sent, chars_sent, checked_n);
        $display("wrap widths from 0 to 65535, line heights 0 to 255, mode changes mid-string");
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
